// File: design/bcpu_pkg.sv
// ----------------------------------------------------------------------------
// bcpu_pkg
// Mnemonic codes, flag positions and payload types for the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package bcpu_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
		OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
		OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
		OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
		OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
		OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
		OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
		OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
		OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
		OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
		OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
		OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
		OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
		OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
	} op_t;

	localparam logic [15:0] STACK_BASE = 16'h0100;
	localparam logic [7:0]  SP_RESET   = 8'hFD;

	typedef struct packed {
		logic n, v, d, i, z, c;
	} flags_t;

	typedef struct packed {
		logic [5:0]  action;
		logic        to_accumulator;
		logic [7:0]  data;
		logic [15:0] target;
		logic [1:0]  instr_length;
		logic [7:0]  pulled_first;
		logic [7:0]  pulled_second;
		logic [7:0]  pulled_third;
	} item_in_t;

	typedef struct packed {
		logic [7:0]  acc;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  stack_ptr;
		logic [7:0]  status;
		logic [15:0] prog_counter;
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        last;
	} item_out_t;

	typedef struct packed {
		logic [7:0]  a, x, y, sp;
		logic [15:0] pc;
		flags_t      f;
	} arch_t;

	typedef struct packed {
		logic        we;
		logic [15:0] wa;
		logic [7:0]  wd;
	} wr_t;

	function automatic logic [7:0] pack_status(flags_t f);
		return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
	endfunction

endpackage
`default_nettype wire

// File: design/bcpu_stream_if.sv
// ----------------------------------------------------------------------------
// bcpu_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface bcpu_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/bcpu_alu.sv
// ----------------------------------------------------------------------------
// bcpu_alu
// Combinational next-state logic for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none
module bcpu_alu
	import bcpu_pkg::*;
(
	input  item_in_t in,
	input  arch_t    cur,
	output arch_t    nxt,
	output wr_t      wr,
	output logic [7:0] jsr_lo
);
	logic [15:0] pc_len, ret;
	logic [7:0]  m, v, r, cmp_reg;
	logic        cin, br, rmw;
	logic [8:0]  bin_add, bin_sub, cmp_diff;
	logic [4:0]  alo;
	logic [8:0]  as_s;
	logic signed [5:0] slo;
	logic signed [9:0] ss;
	logic [9:0]  ssu;
	logic [9:0]  as_fix;

	always_comb begin
		pc_len = cur.pc + {14'd0, in.instr_length};
		ret = pc_len - 16'd1;
		m = in.data;
		cin = cur.f.c;
		v = in.to_accumulator ? cur.a : m;
		bin_add = {1'b0, cur.a} + {1'b0, m} + {8'd0, cin};
		bin_sub = {1'b0, cur.a} + {1'b0, ~m} + {8'd0, cin};
		// decimal add: low nibble fix then high
		alo = {1'b0, cur.a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
		if (alo >= 5'h0A) alo = {1'b0, 4'(alo[3:0] + 4'h6)} + 5'h10;
		as_s = {1'b0, cur.a[7:4], 4'h0} + {1'b0, m[7:4], 4'h0} + {4'd0, alo};
		as_fix = ({1'b0, as_s} >= 10'h0A0) ? {1'b0, as_s} + 10'h060 : {1'b0, as_s};
		// decimal subtract
		slo = $signed({2'b0, cur.a[3:0]}) - $signed({2'b0, m[3:0]})
			+ $signed({5'b0, cin}) - 6'sd1;
		if (slo < 0) slo = $signed({2'b0, 4'(slo[3:0] + 4'hA)}) - 6'sd16;
		ss = $signed({2'b0, cur.a[7:4], 4'h0}) - $signed({2'b0, m[7:4], 4'h0})
			+ 10'(slo);
		if (ss < 0) ss = ss - 10'sd96;
		ssu = 10'(ss);
		case (in.action)
			OP_CMP: cmp_reg = cur.a;
			OP_CPX: cmp_reg = cur.x;
			default: cmp_reg = cur.y;
		endcase
		cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

		nxt = cur;
		nxt.pc = pc_len;
		wr = '0;
		br = 1'b0;
		rmw = 1'b0;
		r = '0;
		jsr_lo = ret[7:0];
		case (in.action)
			OP_ADC: begin
				if (cur.f.d) begin
					nxt.f.z = (bin_add[7:0] == 8'd0);
					nxt.f.n = as_s[7];
					nxt.f.v = ~(cur.a[7] ^ m[7]) & (cur.a[7] ^ as_s[7]);
					nxt.f.c = |as_fix[9:8];
					nxt.a = as_fix[7:0];
				end else begin
					nxt.a = bin_add[7:0];
					nxt.f.c = bin_add[8];
					nxt.f.v = ~(cur.a[7] ^ m[7]) & (cur.a[7] ^ bin_add[7]);
					nxt.f.n = bin_add[7];
					nxt.f.z = (bin_add[7:0] == 8'd0);
				end
			end
			OP_SBC: begin
				nxt.f.c = bin_sub[8];
				nxt.f.v = (cur.a[7] ^ m[7]) & (cur.a[7] ^ bin_sub[7]);
				nxt.f.n = bin_sub[7];
				nxt.f.z = (bin_sub[7:0] == 8'd0);
				nxt.a = cur.f.d ? ssu[7:0] : bin_sub[7:0];
			end
			OP_AND: begin nxt.a = cur.a & m; end
			OP_EOR: begin nxt.a = cur.a ^ m; end
			OP_ORA: begin nxt.a = cur.a | m; end
			OP_ASL: begin nxt.f.c = v[7]; r = {v[6:0], 1'b0}; rmw = 1'b1; end
			OP_LSR: begin nxt.f.c = v[0]; r = {1'b0, v[7:1]}; rmw = 1'b1; end
			OP_ROL: begin nxt.f.c = v[7]; r = {v[6:0], cin}; rmw = 1'b1; end
			OP_ROR: begin nxt.f.c = v[0]; r = {cin, v[7:1]}; rmw = 1'b1; end
			OP_BCC: br = ~cur.f.c;
			OP_BCS: br = cur.f.c;
			OP_BEQ: br = cur.f.z;
			OP_BNE: br = ~cur.f.z;
			OP_BMI: br = cur.f.n;
			OP_BPL: br = ~cur.f.n;
			OP_BVC: br = ~cur.f.v;
			OP_BVS: br = cur.f.v;
			OP_BIT: begin
				nxt.f.z = ((cur.a & m) == 8'd0);
				nxt.f.n = m[7];
				nxt.f.v = m[6];
			end
			OP_CLC: nxt.f.c = 1'b0;
			OP_CLD: nxt.f.d = 1'b0;
			OP_CLI: nxt.f.i = 1'b0;
			OP_CLV: nxt.f.v = 1'b0;
			OP_SEC: nxt.f.c = 1'b1;
			OP_SED: nxt.f.d = 1'b1;
			OP_SEI: nxt.f.i = 1'b1;
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.f.c = ~cmp_diff[8];
				nxt.f.n = cmp_diff[7];
				nxt.f.z = (cmp_diff[7:0] == 8'd0);
			end
			OP_DEC: begin wr = '{1'b1, in.target, m - 8'd1}; end
			OP_INC: begin wr = '{1'b1, in.target, m + 8'd1}; end
			OP_DEX: nxt.x = cur.x - 8'd1;
			OP_DEY: nxt.y = cur.y - 8'd1;
			OP_INX: nxt.x = cur.x + 8'd1;
			OP_INY: nxt.y = cur.y + 8'd1;
			OP_JMP: nxt.pc = in.target;
			OP_JSR: begin
				nxt.sp = cur.sp - 8'd2;
				nxt.pc = in.target;
				wr = '{1'b1, STACK_BASE | {8'd0, cur.sp}, ret[15:8]};
			end
			OP_LDA: nxt.a = m;
			OP_LDX: nxt.x = m;
			OP_LDY: nxt.y = m;
			OP_PHA: begin
				wr = '{1'b1, STACK_BASE | {8'd0, cur.sp}, cur.a};
				nxt.sp = cur.sp - 8'd1;
			end
			OP_PHP: begin
				wr = '{1'b1, STACK_BASE | {8'd0, cur.sp}, pack_status(cur.f) | 8'h30};
				nxt.sp = cur.sp - 8'd1;
			end
			OP_PLA: begin nxt.sp = cur.sp + 8'd1; nxt.a = in.pulled_first; end
			OP_PLP: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.f = '{in.pulled_first[7], in.pulled_first[6], in.pulled_first[3],
					in.pulled_first[2], in.pulled_first[1], in.pulled_first[0]};
			end
			OP_RTI: begin
				nxt.sp = cur.sp + 8'd3;
				nxt.f = '{in.pulled_first[7], in.pulled_first[6], in.pulled_first[3],
					in.pulled_first[2], in.pulled_first[1], in.pulled_first[0]};
				nxt.pc = {in.pulled_third, in.pulled_second};
			end
			OP_RTS: begin
				nxt.sp = cur.sp + 8'd2;
				nxt.pc = {in.pulled_second, in.pulled_first} + 16'd1;
			end
			OP_STA: wr = '{1'b1, in.target, cur.a};
			OP_STX: wr = '{1'b1, in.target, cur.x};
			OP_STY: wr = '{1'b1, in.target, cur.y};
			OP_TAX: nxt.x = cur.a;
			OP_TAY: nxt.y = cur.a;
			OP_TSX: nxt.x = cur.sp;
			OP_TXA: nxt.a = cur.x;
			OP_TXS: nxt.sp = cur.x;
			OP_TYA: nxt.a = cur.y;
			default: ;
		endcase
		// N/Z for results that land in a register or memory byte
		case (in.action)
			OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
				nxt.f.n = nxt.a[7]; nxt.f.z = (nxt.a == 8'd0);
			end
			OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
				nxt.f.n = nxt.x[7]; nxt.f.z = (nxt.x == 8'd0);
			end
			OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
				nxt.f.n = nxt.y[7]; nxt.f.z = (nxt.y == 8'd0);
			end
			OP_DEC, OP_INC: begin
				nxt.f.n = wr.wd[7]; nxt.f.z = (wr.wd == 8'd0);
			end
			default: ;
		endcase
		if (rmw) begin
			nxt.f.n = r[7];
			nxt.f.z = (r == 8'd0);
			if (in.to_accumulator) nxt.a = r;
			else wr = '{1'b1, in.target, r};
		end
		if (br) nxt.pc = pc_len + {{8{m[7]}}, m};
	end
endmodule
`default_nettype wire

// File: design/eight_bit_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Executes one decoded 6502 instruction per transaction and reports the
// architectural registers and any memory write it makes.
// ----------------------------------------------------------------------------
//  channel | dir | payload     | transactions per instruction
//  ------- | --- | ----------- | ----------------------------
//  in_ch   | in  | item_in_t   | 1
//  out_ch  | out | item_out_t  | 1, or 2 for JSR (high push, then low push)
//
// An instruction is executed in the cycle it is accepted and its result is
// registered; one instruction per cycle is sustained while the sink takes
// results. JSR holds the input until its second push result is loaded into
// the result register. On reset A, X, Y and PC clear, SP is 0xFD and only I
// is set. A stalled sink holds the result register and blocks input.
// ----------------------------------------------------------------------------
`default_nettype none
module eight_bit_cpu_execute_unit
	import bcpu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bcpu_stream_if.sink   in_ch,
	bcpu_stream_if.source out_ch
);
	arch_t      arch_q, nxt;
	wr_t        wr;
	logic [7:0] jsr_lo;
	item_out_t  res_q;
	logic       res_valid_q;
	// second JSR push waiting behind the current result
	logic       pend_q;
	logic [15:0] pend_addr_q;
	logic [7:0] pend_data_q;
	logic       out_free, take;

	bcpu_alu u_alu (
		.in     (in_ch.payload),
		.cur    (arch_q),
		.nxt    (nxt),
		.wr     (wr),
		.jsr_lo (jsr_lo)
	);

	assign out_free    = ~res_valid_q | out_ch.ready;
	assign in_ch.ready = out_free & ~pend_q;
	assign take        = in_ch.valid & in_ch.ready;
	assign out_ch.valid   = res_valid_q;
	assign out_ch.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q      <= '{8'd0, 8'd0, 8'd0, SP_RESET, 16'd0,
				'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}};
			res_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (take) begin
				// advance architectural state and load the first result
				arch_q      <= nxt;
				res_valid_q <= 1'b1;
				pend_q      <= (in_ch.payload.action == OP_JSR);
			end else if (out_free) begin
				// release the JSR low push, or drop the shown result
				res_valid_q <= pend_q;
				pend_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.acc           <= nxt.a;
			res_q.index_x       <= nxt.x;
			res_q.index_y       <= nxt.y;
			res_q.stack_ptr     <= nxt.sp;
			res_q.status        <= pack_status(nxt.f);
			res_q.prog_counter  <= nxt.pc;
			res_q.write_enable  <= wr.we;
			res_q.write_address <= wr.we ? wr.wa : 16'd0;
			res_q.write_data    <= wr.we ? wr.wd : 8'd0;
			res_q.last          <= (in_ch.payload.action != OP_JSR);
			pend_addr_q         <= STACK_BASE | {8'd0, 8'(arch_q.sp - 8'd1)};
			pend_data_q         <= jsr_lo;
		end else if (out_free && pend_q) begin
			res_q.write_address <= pend_addr_q;
			res_q.write_data    <= pend_data_q;
			res_q.last          <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: design/bcpu_checker.sv
// ----------------------------------------------------------------------------
// bcpu_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bcpu_checker
	import bcpu_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire item_out_t out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed while stalled");
	a_jsr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_payload.last |=> out_valid && out_payload.last)
		else $error("JSR second push missing");
	a_no_in_mid_jsr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.last |-> !(in_valid && in_ready))
		else $error("input taken during JSR pair");
	a_sp_after_jsr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_payload.last |=>
		out_payload.write_address[7:0] == $past(out_payload.write_address[7:0]) - 8'd1)
		else $error("JSR low push address wrong");
endmodule

bind eight_bit_cpu_execute_unit bcpu_checker u_bcpu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
`default_nettype wire
